// ===== sv/assert_macros.svh =====
// Assertion macros shared by the fan speed controller modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define FSC_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fan controller check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define FSC_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fan controller check failed");

`endif

// ===== sv/fsc_pkg.sv =====
// Types, constants and register codes of the fan speed controller.
`timescale 1ns / 1ps

package fsc_pkg;

	// Field widths.
	localparam int TEMP_W   = 12;
	localparam int DRIVE_W  = 10;
	localparam int SMOOTH_W = 18;
	localparam int GAIN_W   = 16;
	localparam int PCT_W    = 7;
	localparam int TACHO_W  = 8;
	localparam int FRAC_W   = 8;

	// Serial multiplier geometry: operand widths and bits retired per cycle.
	localparam int MUL_XW  = 18;
	localparam int MUL_YW  = 16;
	localparam int DIGIT_W = 2;

	// Configuration port.
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	// Parameter defaults.
	localparam int TACHO_RELOAD_DEF = 200;
	localparam int SMOOTH_SHIFT_DEF = 5;

	// Register reset values.
	localparam logic signed [TEMP_W-1:0] STOP_TEMP_RST  = 12'sd500;
	localparam logic signed [TEMP_W-1:0] START_TEMP_RST = 12'sd550;
	localparam logic signed [TEMP_W-1:0] FULL_TEMP_RST  = 12'sd750;
	localparam logic [DRIVE_W-1:0]       FULL_DRIVE_RST = 10'd953;
	localparam logic [SMOOTH_W-1:0]      MIN_SPEED_RST  = 18'd73114;
	localparam logic [SMOOTH_W-1:0]      START_SPEED_RST = 18'd121856;
	localparam logic [GAIN_W-1:0]        RAMP_GAIN_RST  = 16'd853;
	localparam logic [GAIN_W-1:0]        PCT_GAIN_RST   = 16'd6884;

	// Saturation limits.
	localparam logic [DRIVE_W-1:0] DRIVE_MAX = 10'd1023;
	localparam logic [PCT_W-1:0]   PCT_MAX   = 7'd100;

	// Register indexes on the configuration port.
	typedef enum logic [2:0] {
		REG_STOP_TEMP,
		REG_START_TEMP,
		REG_FULL_TEMP,
		REG_FULL_DRIVE,
		REG_MIN_SPEED,
		REG_START_SPEED,
		REG_RAMP_GAIN,
		REG_PCT_GAIN
	} fsc_reg_t;

	// Command codes.
	typedef enum logic {
		OP_REGULATE,
		OP_TACHO
	} fsc_op_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RAMP_GO,
		ST_RAMP_WAIT,
		ST_TARGET,
		ST_STEP,
		ST_APPLY,
		ST_PCT_GO,
		ST_PCT_WAIT,
		ST_FINISH
	} fsc_state_t;

	// Command word.
	typedef struct packed {
		fsc_op_t                   opcode;
		logic signed [TEMP_W-1:0]  cpu_temp;
		logic signed [TEMP_W-1:0]  ext_temp;
		logic                      rotation_level;
	} fsc_cmd_t;

	// Result word.
	typedef struct packed {
		logic [DRIVE_W-1:0]        pwm_compare;
		logic [PCT_W-1:0]          drive_percent;
		logic signed [TEMP_W-1:0]  shown_temp;
		logic [TACHO_W-1:0]        tacho_count;
	} fsc_res_t;

endpackage

// ===== sv/fsc_cmd_if.sv =====
// Valid/ready channel that carries command words into the controller.
`timescale 1ns / 1ps

interface fsc_cmd_if;
	logic              valid;
	logic              ready;
	fsc_pkg::fsc_cmd_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/fsc_res_if.sv =====
// Valid/ready channel that carries result words out of the controller.
`timescale 1ns / 1ps

interface fsc_res_if;
	logic              valid;
	logic              ready;
	fsc_pkg::fsc_res_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/fsc_serial_mul.sv =====
// Digit-serial unsigned shift-and-add multiplier, DW multiplier bits per cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fsc_serial_mul #(
	parameter int XW = fsc_pkg::MUL_XW,
	parameter int YW = fsc_pkg::MUL_YW,
	parameter int DW = fsc_pkg::DIGIT_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [XW-1:0]        x,
	input  logic [YW-1:0]        y,
	output logic                 done,
	output logic [XW+DW+YW-1:0]  prod
);

	localparam int NDIG = YW / DW;
	localparam int CW   = (NDIG > 1) ? $clog2(NDIG) : 1;
	localparam int HW   = XW + DW;
	localparam logic [CW-1:0] LAST = CW'(NDIG - 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic [HW-1:0] h_q;
	logic [YW-1:0] lo_q;
	logic [HW-1:0] pp;
	logic [HW:0]   sum;

	// Partial product of the multiplicand and the lowest multiplier digit.
	always_comb begin
		pp = '0;
		for (int i = 0; i < DW; i++) begin
			if (y_q[i]) begin
				pp = pp + (HW'(x_q) << i);
			end
		end
		sum = {1'b0, h_q} + {1'b0, pp};
	end

	// Sequencing: count digits, flag the cycle after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Accumulator: the upper part adds a digit product, low digits shift out.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q  <= x;
			y_q  <= y;
			h_q  <= '0;
			lo_q <= '0;
		end else if (busy_q) begin
			y_q  <= y_q >> DW;
			h_q  <= HW'(sum >> DW);
			lo_q <= {sum[DW-1:0], lo_q[YW-1:DW]};
		end
	end

	assign done = done_q;
	assign prod = {h_q, lo_q};

	`FSC_ASSERT_NOW(a_start_idle, start, !busy_q)
	`FSC_ASSERT_NEXT(a_done_after_last, busy_q && !start && cnt_q == LAST, done_q && !busy_q)

endmodule

// ===== sv/fan_speed_controller.sv =====
// Top level of the temperature-driven fan speed controller.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage. Command words enter on cmd; each yields exactly one result word on res.
// A regulation word takes the larger of two temperatures, picks a target drive
// (full, linear ramp, off or hold) and moves the smoothed drive toward it; a
// tacho word samples the rotation pin and updates the stall watchdog. Every
// result reports the PWM compare value, the drive percent, the last temperature
// and the watchdog count. Both multiplies (ramp and percent) run on one shared
// multiplier that retires two multiplier bits per cycle. One word is at work at
// a time; cmd.ready is high only while the sequencer is idle. The result sits in
// an output register, so a new word is accepted while a result waits; if res is
// stalled when the next result is done, the sequencer holds it until the
// register frees. Configuration must be written over the APB port while idle;
// the block does not enforce it. Reset is asynchronous and active low:
// registers return to their defaults and the target and smoothed drive, the
// temperature and the watchdog clear to zero.

module fan_speed_controller #(
	parameter int TACHO_RELOAD = fsc_pkg::TACHO_RELOAD_DEF,
	parameter int SMOOTH_SHIFT = fsc_pkg::SMOOTH_SHIFT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	fsc_cmd_if.sink                    cmd,
	fsc_res_if.source                  res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fsc_pkg::APB_AW-1:0] paddr,
	input  logic [fsc_pkg::APB_DW-1:0] pwdata,
	output logic [fsc_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);

	localparam int TW = fsc_pkg::TEMP_W;
	localparam int DRW = fsc_pkg::DRIVE_W;
	localparam int SW = fsc_pkg::SMOOTH_W;
	localparam int GW = fsc_pkg::GAIN_W;
	localparam int PW = fsc_pkg::PCT_W;
	localparam int CW = fsc_pkg::TACHO_W;
	localparam int FW = fsc_pkg::FRAC_W;
	localparam int XW = fsc_pkg::MUL_XW;
	localparam int YW = fsc_pkg::MUL_YW;
	localparam int DW = fsc_pkg::DIGIT_W;
	localparam int MW = XW + DW + YW;
	localparam int RAMP_PW = TW + GW + 2;
	localparam int PCT_LSB = 2 * FW + FW;
	localparam logic [CW-1:0] RELOAD_V = CW'(TACHO_RELOAD);

	// Configuration registers.
	logic signed [TW-1:0] stop_temp_q;
	logic signed [TW-1:0] start_temp_q;
	logic signed [TW-1:0] full_temp_q;
	logic [DRW-1:0]       full_drive_q;
	logic [SW-1:0]        min_speed_q;
	logic [SW-1:0]        start_speed_q;
	logic [GW-1:0]        ramp_gain_q;
	logic [GW-1:0]        pct_gain_q;

	// Controller state.
	fsc_pkg::fsc_state_t  state_q;
	fsc_pkg::fsc_state_t  state_d;
	logic [DRW-1:0]       target_q;
	logic [SW-1:0]        smoothed_q;
	logic signed [TW-1:0] last_temp_q;
	logic                 pin_phase_q;
	logic [CW-1:0]        wd_q;
	logic [SW-1:0]        step_q;
	logic                 up_q;
	logic [PW-1:0]        pct_q;
	logic                 res_valid_q;
	fsc_pkg::fsc_res_t    res_q;

	// Multiplier hookup.
	logic                 mul_start;
	logic                 mul_sel_ramp;
	logic [XW-1:0]        mul_x;
	logic [YW-1:0]        mul_y;
	logic                 mul_done;
	logic [MW-1:0]        mul_prod;

	// Datapath helpers.
	logic                 cfg_wr;
	logic                 cmd_take;
	logic                 out_free;
	logic signed [TW-1:0] hot_temp;
	logic [TW:0]          temp_diff;
	logic [RAMP_PW:0]     ramp_sum;
	logic [RAMP_PW-FW:0]  ramp_t;
	logic [DRW-1:0]       ramp_sat;
	logic [SW-1:0]        goal;
	logic                 goal_ge;
	logic [SW-1:0]        gap;
	logic [MW-PCT_LSB-1:0] pct_raw;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign cmd_take = cmd.valid && cmd.ready;
	assign out_free = !res_valid_q || res.ready;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_temp_q   <= fsc_pkg::STOP_TEMP_RST;
			start_temp_q  <= fsc_pkg::START_TEMP_RST;
			full_temp_q   <= fsc_pkg::FULL_TEMP_RST;
			full_drive_q  <= fsc_pkg::FULL_DRIVE_RST;
			min_speed_q   <= fsc_pkg::MIN_SPEED_RST;
			start_speed_q <= fsc_pkg::START_SPEED_RST;
			ramp_gain_q   <= fsc_pkg::RAMP_GAIN_RST;
			pct_gain_q    <= fsc_pkg::PCT_GAIN_RST;
		end else if (cfg_wr) begin
			unique case (fsc_pkg::fsc_reg_t'(paddr[4:2]))
				fsc_pkg::REG_STOP_TEMP:   stop_temp_q   <= pwdata[TW-1:0];
				fsc_pkg::REG_START_TEMP:  start_temp_q  <= pwdata[TW-1:0];
				fsc_pkg::REG_FULL_TEMP:   full_temp_q   <= pwdata[TW-1:0];
				fsc_pkg::REG_FULL_DRIVE:  full_drive_q  <= pwdata[DRW-1:0];
				fsc_pkg::REG_MIN_SPEED:   min_speed_q   <= pwdata[SW-1:0];
				fsc_pkg::REG_START_SPEED: start_speed_q <= pwdata[SW-1:0];
				fsc_pkg::REG_RAMP_GAIN:   ramp_gain_q   <= pwdata[GW-1:0];
				fsc_pkg::REG_PCT_GAIN:    pct_gain_q    <= pwdata[GW-1:0];
				default: ;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		unique case (fsc_pkg::fsc_reg_t'(paddr[4:2]))
			fsc_pkg::REG_STOP_TEMP:   prdata = 32'($unsigned(stop_temp_q));
			fsc_pkg::REG_START_TEMP:  prdata = 32'($unsigned(start_temp_q));
			fsc_pkg::REG_FULL_TEMP:   prdata = 32'($unsigned(full_temp_q));
			fsc_pkg::REG_FULL_DRIVE:  prdata = 32'(full_drive_q);
			fsc_pkg::REG_MIN_SPEED:   prdata = 32'(min_speed_q);
			fsc_pkg::REG_START_SPEED: prdata = 32'(start_speed_q);
			fsc_pkg::REG_RAMP_GAIN:   prdata = 32'(ramp_gain_q);
			fsc_pkg::REG_PCT_GAIN:    prdata = 32'(pct_gain_q);
			default:                  prdata = '0;
		endcase
	end

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fsc_pkg::ST_IDLE: begin
				if (cmd.valid) begin
					state_d = (cmd.payload.opcode == fsc_pkg::OP_REGULATE) ?
						fsc_pkg::ST_RAMP_GO : fsc_pkg::ST_PCT_GO;
				end
			end
			fsc_pkg::ST_RAMP_GO:   state_d = fsc_pkg::ST_RAMP_WAIT;
			fsc_pkg::ST_RAMP_WAIT: if (mul_done) state_d = fsc_pkg::ST_TARGET;
			fsc_pkg::ST_TARGET:    state_d = fsc_pkg::ST_STEP;
			fsc_pkg::ST_STEP: begin
				state_d = (target_q != '0 && smoothed_q != '0) ?
					fsc_pkg::ST_APPLY : fsc_pkg::ST_PCT_GO;
			end
			fsc_pkg::ST_APPLY:     state_d = fsc_pkg::ST_PCT_GO;
			fsc_pkg::ST_PCT_GO:    state_d = fsc_pkg::ST_PCT_WAIT;
			fsc_pkg::ST_PCT_WAIT:  if (mul_done) state_d = fsc_pkg::ST_FINISH;
			fsc_pkg::ST_FINISH:    if (out_free) state_d = fsc_pkg::ST_IDLE;
			default:               state_d = fsc_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		cmd.ready    = (state_q == fsc_pkg::ST_IDLE);
		mul_start    = (state_q == fsc_pkg::ST_RAMP_GO) || (state_q == fsc_pkg::ST_PCT_GO);
		mul_sel_ramp = (state_q == fsc_pkg::ST_RAMP_GO);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Larger temperature and ramp offset above the start threshold.
	assign hot_temp  = (cmd.payload.cpu_temp > cmd.payload.ext_temp) ?
		cmd.payload.cpu_temp : cmd.payload.ext_temp;
	assign temp_diff = {last_temp_q[TW-1], last_temp_q} - {start_temp_q[TW-1], start_temp_q};

	// Operand select for the shared multiplier.
	assign mul_x = mul_sel_ramp ? XW'(temp_diff[TW-1:0]) : smoothed_q;
	assign mul_y = mul_sel_ramp ? ramp_gain_q : pct_gain_q;

	fsc_serial_mul #(
		.XW (XW),
		.YW (YW),
		.DW (DW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (mul_x),
		.y      (mul_y),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// Ramp target: base plus product, drop the fraction, clamp to the top count.
	assign ramp_sum = (RAMP_PW+1)'(mul_prod[RAMP_PW-1:0]) + (RAMP_PW+1)'(min_speed_q);
	assign ramp_t   = ramp_sum[RAMP_PW:FW];
	assign ramp_sat = (ramp_t > (RAMP_PW-FW+1)'(fsc_pkg::DRIVE_MAX)) ?
		fsc_pkg::DRIVE_MAX : ramp_t[DRW-1:0];

	// Distance from the smoothed drive to the target.
	assign goal    = {target_q, {FW{1'b0}}};
	assign goal_ge = (goal >= smoothed_q);
	assign gap     = goal_ge ? (goal - smoothed_q) : (smoothed_q - goal);

	// Percent of period, saturated.
	assign pct_raw = mul_prod[MW-1:PCT_LSB];

	// Model state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= '0;
			smoothed_q  <= '0;
			last_temp_q <= '0;
			pin_phase_q <= 1'b0;
			wd_q        <= '0;
		end else begin
			if (cmd_take) begin
				if (cmd.payload.opcode == fsc_pkg::OP_REGULATE) begin
					last_temp_q <= hot_temp;
				end else if (cmd.payload.rotation_level == pin_phase_q) begin
					// Expected pin edge: flip phase, rearm the watchdog.
					pin_phase_q <= ~pin_phase_q;
					wd_q        <= RELOAD_V;
				end else if (wd_q != '0) begin
					wd_q <= wd_q - 1'b1;
				end
			end
			if (state_q == fsc_pkg::ST_TARGET) begin
				priority if (last_temp_q > full_temp_q) begin
					target_q <= full_drive_q;
				end else if (last_temp_q > start_temp_q) begin
					target_q <= ramp_sat;
				end else if (last_temp_q < stop_temp_q) begin
					target_q <= '0;
				end else begin
					// Inside the hysteresis band the target holds.
					target_q <= target_q;
				end
			end
			if (state_q == fsc_pkg::ST_STEP) begin
				if (target_q == '0) begin
					smoothed_q <= '0;
				end else if (smoothed_q == '0) begin
					// Soft start from standstill.
					smoothed_q <= start_speed_q;
					wd_q       <= RELOAD_V;
				end
			end
			if (state_q == fsc_pkg::ST_APPLY) begin
				smoothed_q <= up_q ? (smoothed_q + step_q) : (smoothed_q - step_q);
			end
		end
	end

	// Smoothing step and percent hold registers.
	always_ff @(posedge clk) begin
		if (state_q == fsc_pkg::ST_STEP) begin
			step_q <= gap >> SMOOTH_SHIFT;
			up_q   <= goal_ge;
		end
		if (state_q == fsc_pkg::ST_PCT_WAIT && mul_done) begin
			pct_q <= (pct_raw > (MW-PCT_LSB)'(fsc_pkg::PCT_MAX)) ?
				fsc_pkg::PCT_MAX : pct_raw[PW-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == fsc_pkg::ST_FINISH && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fsc_pkg::ST_FINISH && out_free) begin
			res_q.pwm_compare   <= smoothed_q[SW-1:FW];
			res_q.drive_percent <= pct_q;
			res_q.shown_temp    <= last_temp_q;
			res_q.tacho_count   <= wd_q;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.payload = res_q;

	`FSC_ASSERT_NOW(a_done_when_waiting, mul_done, state_q == fsc_pkg::ST_RAMP_WAIT || state_q == fsc_pkg::ST_PCT_WAIT)
	`FSC_ASSERT_NOW(a_pct_saturated, res_valid_q, res_q.drive_percent <= fsc_pkg::PCT_MAX)
	`FSC_ASSERT_NEXT(a_soft_start, state_q == fsc_pkg::ST_STEP && target_q != '0 && smoothed_q == '0, wd_q == RELOAD_V && smoothed_q == $past(start_speed_q))
	`FSC_ASSERT_NEXT(a_regulate_path, cmd_take && cmd.payload.opcode == fsc_pkg::OP_REGULATE, state_q == fsc_pkg::ST_RAMP_GO)

endmodule
